/* hw/rtl/lvp_pkg.sv */
// ----------------------------------------------------------------------------
// lvp_pkg
// shared types, constants and helper functions of the vibrato pitch engine
// ----------------------------------------------------------------------------
package lvp_pkg;

  // table geometry
  localparam int PITCH_TABLE_DEPTH = 608;
  localparam int WAVE_DEPTH        = 60;
  localparam int PITCH_ADDR_W      = $clog2(PITCH_TABLE_DEPTH);
  localparam int WAVE_ADDR_W       = $clog2(WAVE_DEPTH);

  // item field widths
  localparam int MODE_W  = 2;
  localparam int KEY_W   = 7;
  localparam int INDEX_W = 10;
  localparam int VALUE_W = 16;
  localparam int WORD_W  = 16;
  localparam int BEND_W  = 9;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [6:0] RATE_RESET  = 7'd0;
  localparam logic [6:0] DEPTH_RESET = 7'd0;
  localparam logic [6:0] ROOT_RESET  = 7'd60;
  localparam logic [7:0] TUNE_RESET  = 8'd0;
  localparam logic [6:0] RANGE_RESET = 7'd2;
  localparam logic       TRI_RESET   = 1'b1;

  // lfo and pitch arithmetic
  localparam logic [8:0]  PHASE_WRAP   = 9'd240;
  localparam logic [2:0]  RELOAD_COUNT = 3'd6;
  localparam logic [18:0] RATE_RECIP   = 19'd478906;     // 58 * ceil(2^20 / 127)
  localparam int          RATE_RECIP_SH = 20;
  localparam logic [9:0]  BEND_CENTER  = 10'd64;
  localparam logic [7:0]  DIV12_RECIP  = 8'd171;         // ceil(2^11 / 12)
  localparam logic [3:0]  SEMITONES    = 4'd12;
  localparam logic [11:0] BASE_OFFSET  = 12'd208;
  localparam logic [31:0] PITCH_SCALE  = 32'd441;
  localparam logic [28:0] DIV15_RECIP  = 29'd286331154;  // (2^32 + 14) / 15
  localparam logic [15:0] STEP_LIMIT   = 16'h3FFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK       = 2'd0,
    MODE_PITCH_LOAD = 2'd1,
    MODE_WAVE_LOAD  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_RATE  = 3'd0,
    REG_DEPTH = 3'd1,
    REG_ROOT  = 3'd2,
    REG_TUNE  = 3'd3,
    REG_RANGE = 3'd4,
    REG_TRI   = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PHASE,
    ST_SCALE,
    ST_BEND,
    ST_SPAN,
    ST_NOTE,
    ST_QUOT,
    ST_INDEX,
    ST_LOOK,
    ST_MUL,
    ST_DLO,
    ST_DHI,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [6:0]        rate;
    logic [6:0]        depth;
    logic [6:0]        root;
    logic signed [7:0] fine_tune;
    logic [6:0]        bend_range;
    logic              use_tri;
    logic [6:0]        step;
    logic              phase_clear;
  } cfg_t;

  // phase step per advance, indexed by floor(rate * 58 / 127)
  function automatic logic [6:0] lfo_step_of(input logic [5:0] q);
    logic [6:0] s;
    case (q) inside
      [6'd0:6'd11]:  s = 7'd4;
      [6'd12:6'd19]: s = 7'd5;
      [6'd20:6'd25]: s = 7'd6;
      [6'd26:6'd29]: s = 7'd7;
      [6'd30:6'd33]: s = 7'd8;
      [6'd34:6'd35]: s = 7'd9;
      [6'd36:6'd38]: s = 7'd10;
      6'd39:         s = 7'd11;
      [6'd40:6'd41]: s = 7'd12;
      6'd42:         s = 7'd13;
      6'd43:         s = 7'd14;
      6'd44:         s = 7'd15;
      6'd45:         s = 7'd16;
      6'd46:         s = 7'd17;
      6'd47:         s = 7'd18;
      6'd48:         s = 7'd20;
      6'd49:         s = 7'd21;
      6'd50:         s = 7'd24;
      6'd51:         s = 7'd26;
      6'd52:         s = 7'd30;
      6'd53:         s = 7'd34;
      6'd54:         s = 7'd40;
      6'd55:         s = 7'd48;
      6'd56:         s = 7'd60;
      6'd57:         s = 7'd80;
      6'd58:         s = 7'd120;
      default:       s = 7'd0;
    endcase
    return s;
  endfunction

  // default triangle waveform sample
  function automatic logic [7:0] triangle_at(input logic [6:0] i);
    logic [9:0] i8;
    logic [9:0] v;
    i8 = {i, 3'b000};
    if (i <= 7'd14) begin
      v = 10'd128 + i8;
    end else if (i <= 7'd44) begin
      v = 10'd352 - i8;
    end else begin
      v = i8 - 10'd352;
    end
    return v[7:0];
  endfunction

endpackage

/* hw/rtl/lvp_ifs.sv */
// ----------------------------------------------------------------------------
// lvp_in_if / lvp_out_if
// valid/ready item channels of the vibrato pitch engine
// ----------------------------------------------------------------------------
interface lvp_in_if;
  logic                             valid;
  logic                             ready;
  logic [lvp_pkg::MODE_W-1:0]       mode;
  logic [lvp_pkg::KEY_W-1:0]        key;
  logic [lvp_pkg::INDEX_W-1:0]      entry_index;
  logic [lvp_pkg::VALUE_W-1:0]      entry_value;

  modport source (output valid, mode, key, entry_index, entry_value, input ready);
  modport sink   (input valid, mode, key, entry_index, entry_value, output ready);
endinterface

interface lvp_out_if;
  logic                             valid;
  logic                             ready;
  logic [lvp_pkg::WORD_W-1:0]       pitch_word;
  logic signed [lvp_pkg::BEND_W-1:0] bend_value;
  logic                             index_clamped;
  logic                             step_over_limit;

  modport source (output valid, pitch_word, bend_value, index_clamped, step_over_limit,
                  input ready);
  modport sink   (input valid, pitch_word, bend_value, index_clamped, step_over_limit,
                  output ready);
endinterface

/* hw/rtl/lvp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lvp_cfg_regs
// apb register file of the vibrato pitch engine and the lfo step lookup
// ----------------------------------------------------------------------------
module lvp_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lvp_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [lvp_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [lvp_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output lvp_pkg::cfg_t                     cfg
);

  logic              wr_en;
  lvp_pkg::reg_idx_t wr_idx;
  logic [6:0]        rate_r, rate_nxt;
  logic [6:0]        depth_r, depth_nxt;
  logic [6:0]        root_r, root_nxt;
  logic [7:0]        tune_r, tune_nxt;
  logic [6:0]        range_r, range_nxt;
  logic              tri_r, tri_nxt;
  logic [6:0]        step_r, step_nxt;
  logic [25:0]       rate_prod;
  logic              rate_wr;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = lvp_pkg::reg_idx_t'(paddr[4:2]);

  always_comb begin
    rate_nxt  = rate_r;
    depth_nxt = depth_r;
    root_nxt  = root_r;
    tune_nxt  = tune_r;
    range_nxt = range_r;
    tri_nxt   = tri_r;
    rate_wr   = 1'b0;
    if (wr_en) begin
      unique case (wr_idx)
        lvp_pkg::REG_RATE: begin
          rate_nxt = pwdata[6:0];
          rate_wr  = 1'b1;
        end
        lvp_pkg::REG_DEPTH: depth_nxt = pwdata[6:0];
        lvp_pkg::REG_ROOT:  root_nxt  = pwdata[6:0];
        lvp_pkg::REG_TUNE:  tune_nxt  = pwdata[7:0];
        lvp_pkg::REG_RANGE: range_nxt = pwdata[6:0];
        lvp_pkg::REG_TRI:   tri_nxt   = pwdata[0];
        default: ;
      endcase
    end
  end

  // step is registered from the rate register and follows it in the next cycle
  assign rate_prod = 26'(rate_r) * 26'(lvp_pkg::RATE_RECIP);
  assign step_nxt  = (rate_r == 7'd0) ? 7'd0
                   : lvp_pkg::lfo_step_of(rate_prod[lvp_pkg::RATE_RECIP_SH +: 6]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= lvp_pkg::RATE_RESET;
      depth_r <= lvp_pkg::DEPTH_RESET;
      root_r  <= lvp_pkg::ROOT_RESET;
      tune_r  <= lvp_pkg::TUNE_RESET;
      range_r <= lvp_pkg::RANGE_RESET;
      tri_r   <= lvp_pkg::TRI_RESET;
      step_r  <= 7'd0;
    end else begin
      rate_r  <= rate_nxt;
      depth_r <= depth_nxt;
      root_r  <= root_nxt;
      tune_r  <= tune_nxt;
      range_r <= range_nxt;
      tri_r   <= tri_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (lvp_pkg::reg_idx_t'(paddr[4:2]))
      lvp_pkg::REG_RATE:  prdata = 32'(rate_r);
      lvp_pkg::REG_DEPTH: prdata = 32'(depth_r);
      lvp_pkg::REG_ROOT:  prdata = 32'(root_r);
      lvp_pkg::REG_TUNE:  prdata = 32'(tune_r);
      lvp_pkg::REG_RANGE: prdata = 32'(range_r);
      lvp_pkg::REG_TRI:   prdata = 32'(tri_r);
      default:            prdata = '0;
    endcase
  end

  assign cfg.rate        = rate_r;
  assign cfg.depth       = depth_r;
  assign cfg.root        = root_r;
  assign cfg.fine_tune   = tune_r;
  assign cfg.bend_range  = range_r;
  assign cfg.use_tri     = tri_r;
  assign cfg.step        = step_r;
  assign cfg.phase_clear = rate_wr;

endmodule

/* hw/rtl/lfo_vibrato_pitch_engine.sv */
// ----------------------------------------------------------------------------
// lfo_vibrato_pitch_engine
// per-voice vibrato lfo that computes a 16-bit sound-chip pitch word
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one item per handshake: mode 0 is a tick, mode 1 writes a
//   pitch table word, mode 2 writes a waveform byte. loads and unarmed ticks
//   (rate or depth zero) are taken and give no result.
//   an armed tick runs through a 12-step sequencer: phase update and waveform
//   read, depth scaling, bend, semitone split, octave split, pitch table read,
//   octave shift, 441/480 scaling over three multiply steps. the result item
//   is loaded into the out_ch register from the last step, and the next item
//   is taken once the sequencer is back in idle; a load or unarmed tick leaves
//   it idle, so it does not hold off the item behind it.
//   the waveform and pitch table are synchronous memories with a registered
//   read and a separate write port; only the sequencer reads them.
//   when out_ch stalls, the finished item waits in the output register and the
//   input side keeps taking items; a second tick waits at its last step until
//   the register frees. reset clears the configuration registers, phase and
//   countdown; the tables hold unknown data until loaded. writing the rate
//   register over the apb port clears phase and countdown.
// ----------------------------------------------------------------------------
module lfo_vibrato_pitch_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  lvp_in_if.sink                            in_ch,
  lvp_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lvp_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [lvp_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [lvp_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  lvp_pkg::cfg_t   cfg;
  lvp_pkg::state_t state_r, state_nxt;

  logic in_fire;
  logic tick_go;
  logic out_load;
  logic out_valid_r, out_valid_nxt;

  // lfo state
  logic [8:0] phase_r, phase_nxt, phase_adv;
  logic [2:0] cnt_r, cnt_nxt;

  // memories
  logic [15:0] pitch_mem [lvp_pkg::PITCH_TABLE_DEPTH];
  logic [7:0]  wave_mem  [lvp_pkg::WAVE_DEPTH];
  logic [15:0] pitch_rd_r;
  logic [7:0]  wave_rd_r;
  logic [lvp_pkg::PITCH_ADDR_W-1:0] pitch_addr;
  logic [lvp_pkg::WAVE_ADDR_W-1:0]  wave_addr;

  // datapath
  logic [6:0]         key_r;
  logic [7:0]         sample;
  logic [15:0]        y_r;
  logic [16:0]        div_sum;
  logic signed [9:0]  bend_w;
  logic signed [8:0]  bend_r;
  logic               bend_neg;
  logic [8:0]         mag_w;
  logic               neg_r;
  logic [13:0]        m_r;
  logic signed [9:0]  note_w;
  logic signed [9:0]  root_s;
  logic               up_w;
  logic [9:0]         diff_w;
  logic               up_r;
  logic [8:0]         diff_r;
  logic signed [4:0]  fine_r;
  logic [16:0]        q_prod;
  logic [4:0]         q_r;
  logic [8:0]         rem_w;
  logic [3:0]         rem4;
  logic [7:0]         base_w;
  logic signed [11:0] idx_w;
  logic               clamp_w;
  logic               clamped_r;
  logic [31:0]        shifted_w;
  logic [31:0]        shifted_r;
  logic [31:0]        z_r;
  logic [42:0]        pl_r;
  logic [41:0]        ph_r;
  logic [56:0]        quo_sum;
  logic [15:0]        word_w;

  logic [15:0]        word_r;
  logic signed [8:0]  bend_out_r;
  logic               clamped_out_r;
  logic               over_out_r;

  lvp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ch.ready = (state_r == lvp_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign tick_go     = in_fire && (in_ch.mode == lvp_pkg::MODE_TICK)
                    && (cfg.rate != 7'd0) && (cfg.depth != 7'd0);
  assign out_load    = (state_r == lvp_pkg::ST_FIN) && (!out_valid_r || out_ch.ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lvp_pkg::ST_IDLE:  if (tick_go) state_nxt = lvp_pkg::ST_PHASE;
      lvp_pkg::ST_PHASE: state_nxt = lvp_pkg::ST_SCALE;
      lvp_pkg::ST_SCALE: state_nxt = lvp_pkg::ST_BEND;
      lvp_pkg::ST_BEND:  state_nxt = lvp_pkg::ST_SPAN;
      lvp_pkg::ST_SPAN:  state_nxt = lvp_pkg::ST_NOTE;
      lvp_pkg::ST_NOTE:  state_nxt = lvp_pkg::ST_QUOT;
      lvp_pkg::ST_QUOT:  state_nxt = lvp_pkg::ST_INDEX;
      lvp_pkg::ST_INDEX: state_nxt = lvp_pkg::ST_LOOK;
      lvp_pkg::ST_LOOK:  state_nxt = lvp_pkg::ST_MUL;
      lvp_pkg::ST_MUL:   state_nxt = lvp_pkg::ST_DLO;
      lvp_pkg::ST_DLO:   state_nxt = lvp_pkg::ST_DHI;
      lvp_pkg::ST_DHI:   state_nxt = lvp_pkg::ST_FIN;
      lvp_pkg::ST_FIN:   if (out_load) state_nxt = lvp_pkg::ST_IDLE;
      default:           state_nxt = lvp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lvp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // phase and countdown
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    phase_adv = phase_r;
    if (cfg.phase_clear) begin
      phase_nxt = 9'd0;
      cnt_nxt   = 3'd0;
    end else if (state_r == lvp_pkg::ST_PHASE) begin
      if (cnt_r == 3'd0) begin
        cnt_nxt = lvp_pkg::RELOAD_COUNT;
      end else begin
        cnt_nxt   = cnt_r - 3'd1;
        phase_adv = phase_r + 9'(cfg.step);
      end
      if (phase_adv >= lvp_pkg::PHASE_WRAP) begin
        phase_nxt = 9'(cfg.step[6:1]);
      end else begin
        phase_nxt = phase_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 9'd0;
      cnt_r   <= 3'd0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // waveform store
  assign wave_addr = phase_nxt[lvp_pkg::WAVE_ADDR_W+1:2];

  always_ff @(posedge clk) begin
    if (in_fire && (in_ch.mode == lvp_pkg::MODE_WAVE_LOAD)
        && (in_ch.entry_index < lvp_pkg::WAVE_DEPTH)) begin
      wave_mem[in_ch.entry_index[lvp_pkg::WAVE_ADDR_W-1:0]] <= in_ch.entry_value[7:0];
    end
    wave_rd_r <= wave_mem[wave_addr];
  end

  // pitch table
  always_ff @(posedge clk) begin
    if (in_fire && (in_ch.mode == lvp_pkg::MODE_PITCH_LOAD)
        && (in_ch.entry_index < lvp_pkg::PITCH_TABLE_DEPTH)) begin
      pitch_mem[in_ch.entry_index[lvp_pkg::PITCH_ADDR_W-1:0]] <= in_ch.entry_value;
    end
    pitch_rd_r <= pitch_mem[pitch_addr];
  end

  // sample and bend
  always_comb begin
    if (phase_r[8:2] >= 7'(lvp_pkg::WAVE_DEPTH)) begin
      sample = 8'd0;
    end else if (cfg.use_tri) begin
      sample = lvp_pkg::triangle_at(phase_r[8:2]);
    end else begin
      sample = wave_rd_r;
    end
  end

  // divide by 255 for y below 65535
  assign div_sum  = 17'(y_r) + 17'(y_r[15:8]) + 17'd1;
  assign bend_w   = 10'(div_sum[16:8]) - 10'(cfg.depth) + lvp_pkg::BEND_CENTER;
  assign bend_neg = (bend_r < 9'sd64);
  assign mag_w    = bend_neg ? (9'd64 - bend_r) : (bend_r - 9'd64);

  // semitones and octave split
  assign root_s = $signed({3'b000, cfg.root});
  assign note_w = neg_r ? ($signed(10'(key_r)) - $signed(10'(m_r[13:6])))
                        : ($signed(10'(key_r)) + $signed(10'(m_r[13:6])));
  assign up_w   = (note_w >= root_s);
  assign diff_w = up_w ? 10'(note_w - root_s) : 10'(root_s - note_w);
  assign q_prod = 17'(diff_r) * 17'(lvp_pkg::DIV12_RECIP);

  // table index
  assign rem_w  = diff_r - 9'(q_r) * 9'(lvp_pkg::SEMITONES);
  assign rem4   = rem_w[3:0];
  assign base_w = up_r ? {rem4, 4'b0000} : {lvp_pkg::SEMITONES - rem4, 4'b0000};
  assign idx_w  = $signed(12'(base_w)) + $signed(lvp_pkg::BASE_OFFSET)
                + $signed({{4{cfg.fine_tune[7]}}, cfg.fine_tune})
                + $signed({{7{fine_r[4]}}, fine_r});

  always_comb begin
    clamp_w    = 1'b0;
    pitch_addr = idx_w[lvp_pkg::PITCH_ADDR_W-1:0];
    if (idx_w < 0) begin
      clamp_w    = 1'b1;
      pitch_addr = '0;
    end else if (idx_w >= lvp_pkg::PITCH_TABLE_DEPTH) begin
      clamp_w    = 1'b1;
      pitch_addr = lvp_pkg::PITCH_ADDR_W'(lvp_pkg::PITCH_TABLE_DEPTH - 1);
    end
  end

  // octave shift
  always_comb begin
    if (up_r) begin
      shifted_w = {16'd0, pitch_rd_r} << q_r;
    end else if (q_r < 5'd31) begin
      shifted_w = {16'd0, pitch_rd_r} >> (6'(q_r) + 6'd1);
    end else begin
      shifted_w = 32'd0;
    end
  end

  // scale by 441/480: divide by 32, then by 15 through a split reciprocal product
  assign quo_sum = 57'({ph_r, 14'd0}) + 57'(pl_r);
  assign word_w  = quo_sum[47:32];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r <= in_ch.key;
    end
    unique case (state_r)
      lvp_pkg::ST_SCALE: y_r <= 16'(sample) * 16'({cfg.depth, 1'b0});
      lvp_pkg::ST_BEND:  bend_r <= bend_w[8:0];
      lvp_pkg::ST_SPAN: begin
        neg_r <= bend_neg;
        m_r   <= 14'(mag_w[6:0]) * 14'(cfg.bend_range);
      end
      lvp_pkg::ST_NOTE: begin
        up_r   <= up_w;
        diff_r <= diff_w[8:0];
        fine_r <= neg_r ? (5'sd0 - $signed({1'b0, m_r[5:2]})) : $signed({1'b0, m_r[5:2]});
      end
      lvp_pkg::ST_QUOT:  q_r <= q_prod[15:11];
      lvp_pkg::ST_INDEX: clamped_r <= clamp_w;
      lvp_pkg::ST_LOOK:  shifted_r <= shifted_w;
      lvp_pkg::ST_MUL:   z_r <= shifted_r * lvp_pkg::PITCH_SCALE;
      lvp_pkg::ST_DLO:   pl_r <= 43'(z_r[18:5]) * 43'(lvp_pkg::DIV15_RECIP);
      lvp_pkg::ST_DHI:   ph_r <= 42'(z_r[31:19]) * 42'(lvp_pkg::DIV15_RECIP);
      default: ;
    endcase
  end

  // output register
  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      word_r        <= word_w;
      bend_out_r    <= bend_r;
      clamped_out_r <= clamped_r;
      over_out_r    <= (word_w > lvp_pkg::STEP_LIMIT);
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.pitch_word      = word_r;
  assign out_ch.bend_value      = bend_out_r;
  assign out_ch.index_clamped   = clamped_out_r;
  assign out_ch.step_over_limit = over_out_r;

  // checks
  a_phase_below_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r < lvp_pkg::PHASE_WRAP)
    else $error("lfo phase reached the wrap point");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= lvp_pkg::RELOAD_COUNT)
    else $error("tick countdown above reload value");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == lvp_pkg::ST_FIN)
    else $error("result item appeared outside the final step");

  a_table_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lvp_pkg::ST_INDEX |-> pitch_addr < lvp_pkg::PITCH_TABLE_DEPTH)
    else $error("pitch table read beyond its depth");

endmodule

/* sim/lvp_pitch_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lvp_pitch_checker
// watches the item channels and the apb port of the vibrato pitch engine,
// keeps its own copy of the lfo, the tables and the registers, predicts the
// pitch item of every armed tick and compares it field by field in order
// ----------------------------------------------------------------------------
module lvp_pitch_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  lvp_in_if                              in_ch,
  lvp_out_if                             out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [lvp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [lvp_pkg::CFG_DATA_W-1:0] pwdata,
  output int                             fail_count,
  output int                             pending,
  output int                             results_checked
);
  import lvp_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0]        pitch_word;
    logic signed [BEND_W-1:0] bend_value;
    logic                     index_clamped;
    logic                     step_over_limit;
  } pitch_result_t;

  logic [6:0]        vib_rate;
  logic [6:0]        vib_depth;
  logic [6:0]        root_key;
  logic signed [7:0] tune_offset;
  logic [6:0]        bend_span;
  logic              tri_sel;
  logic [8:0]        lfo_phase;
  logic [2:0]        advance_countdown;
  logic [15:0]       pitch_table [PITCH_TABLE_DEPTH];
  logic [7:0]        wave_table [WAVE_DEPTH];

  pitch_result_t expected_pitch_q[$];

  task automatic report_mismatch(input string what);
    if (fail_count < 40) begin
      $display("[%0t] pitch item mismatch: %s", $time, what);
    end
    fail_count++;
  endtask

  function automatic int default_wave_at(input int i);
    int v;
    if (i <= 14) begin
      v = 128 + 8 * i;
    end else if (i <= 44) begin
      v = 352 - 8 * i;
    end else begin
      v = 8 * i - 352;
    end
    return v & 255;
  endfunction

  function automatic bit predict_tick(input logic [KEY_W-1:0] key, output pitch_result_t res);
    int rate_i, step, d, wave_val, bend, span, m, mag, semis, fine;
    int note, root, tune, diff, q, base, idx;
    logic [31:0] word;
    bit up, clamped;
    res = '0;
    rate_i = vib_rate;
    step = (rate_i == 0) ? 0 : 240 / (60 - (rate_i * 58) / 127);
    if (step == 0 || vib_depth == 0) return 1'b0;

    if (advance_countdown == 3'd0) begin
      advance_countdown = 3'd6;
    end else begin
      advance_countdown = advance_countdown - 3'd1;
      lfo_phase = lfo_phase + 9'(step);
    end
    if (lfo_phase >= 9'd240) lfo_phase = 9'(step >> 1);

    d = int'(vib_depth) * 2;
    wave_val = tri_sel ? default_wave_at(int'(lfo_phase >> 2))
                       : int'(wave_table[lfo_phase >> 2]);
    bend = (wave_val * d) / 255 - ((d + 1) >> 1) + 64;

    span = bend_span;
    if (bend >= 64) begin
      m = (bend - 64) * span;
      semis = m >> 6;
      fine = (m >> 2) - semis * 16;
    end else begin
      m = (64 - bend) * span;
      mag = m >> 6;
      semis = -mag;
      fine = mag * 16 - (m >> 2);
    end

    note = int'(key) + semis;
    root = root_key;
    tune = tune_offset;
    up = (note >= root);
    if (up) begin
      diff = note - root;
      q = diff / 12;
      base = (diff % 12) * 16;
    end else begin
      diff = root - note;
      q = diff / 12;
      base = (12 - diff % 12) * 16;
    end
    idx = base + 208 + tune + fine;
    clamped = 1'b0;
    if (idx < 0) begin
      idx = 0;
      clamped = 1'b1;
    end else if (idx >= PITCH_TABLE_DEPTH) begin
      idx = PITCH_TABLE_DEPTH - 1;
      clamped = 1'b1;
    end

    word = {16'h0000, pitch_table[idx]};
    if (up) begin
      word = (q < 32) ? (word << q) : 32'd0;
    end else begin
      word = (q + 1 < 32) ? (word >> (q + 1)) : 32'd0;
    end
    word = (word * 32'd441) / 32'd480;

    res.pitch_word      = word[15:0];
    res.bend_value      = bend[8:0];
    res.index_clamped   = clamped;
    res.step_over_limit = (word[15:0] > 16'h3FFF);
    return 1'b1;
  endfunction

  function automatic void write_setting(input logic [CFG_ADDR_W-1:0] addr,
                                        input logic [CFG_DATA_W-1:0] data);
    case (addr[CFG_ADDR_W-1:2])
      REG_RATE: begin
        vib_rate = data[6:0];
        lfo_phase = '0;
        advance_countdown = '0;
      end
      REG_DEPTH: vib_depth = data[6:0];
      REG_ROOT:  root_key = data[6:0];
      REG_TUNE:  tune_offset = data[7:0];
      REG_RANGE: bend_span = data[6:0];
      REG_TRI:   tri_sel = data[0];
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : monitor
    pitch_result_t want, got;
    if (!rst_n) begin
      vib_rate = RATE_RESET;
      vib_depth = DEPTH_RESET;
      root_key = ROOT_RESET;
      tune_offset = TUNE_RESET;
      bend_span = RANGE_RESET;
      tri_sel = TRI_RESET;
      lfo_phase = '0;
      advance_countdown = '0;
      expected_pitch_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.pitch_word      = out_ch.pitch_word;
        got.bend_value      = out_ch.bend_value;
        got.index_clamped   = out_ch.index_clamped;
        got.step_over_limit = out_ch.step_over_limit;
        if (expected_pitch_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item pitch_word=%h", got.pitch_word));
        end else begin
          want = expected_pitch_q.pop_front();
          results_checked++;
          if (got.pitch_word !== want.pitch_word)
            report_mismatch($sformatf("pitch_word %h, want %h",
                                      got.pitch_word, want.pitch_word));
          if (got.bend_value !== want.bend_value)
            report_mismatch($sformatf("bend_value %0d, want %0d",
                                      got.bend_value, want.bend_value));
          if (got.index_clamped !== want.index_clamped)
            report_mismatch($sformatf("index_clamped %b, want %b",
                                      got.index_clamped, want.index_clamped));
          if (got.step_over_limit !== want.step_over_limit)
            report_mismatch($sformatf("step_over_limit %b, want %b",
                                      got.step_over_limit, want.step_over_limit));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.mode)
          MODE_TICK: begin
            if (predict_tick(in_ch.key, want)) expected_pitch_q.push_back(want);
          end
          MODE_PITCH_LOAD: begin
            if (in_ch.entry_index < PITCH_TABLE_DEPTH)
              pitch_table[in_ch.entry_index] = in_ch.entry_value;
          end
          MODE_WAVE_LOAD: begin
            if (in_ch.entry_index < WAVE_DEPTH)
              wave_table[in_ch.entry_index] = in_ch.entry_value[7:0];
          end
          default: ;
        endcase
      end
      if (psel && penable && pwrite && pready) write_setting(paddr, pwdata);
    end
    pending <= expected_pitch_q.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the vibrato pitch engine: fills the pitch and
// waveform tables, runs directed ticks and loads at extreme settings, a long
// output hold-off, then random item streams over many register settings
// ----------------------------------------------------------------------------
module tb_top;
  import lvp_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int PRESSURE_HOLD  = 400;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 85;
  localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;
  localparam logic [2:0]        REG_UNMAPPED = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int results_checked;
  int items_sent;
  int settings_used;
  int quiet_cycles;
  bit tx_steady;
  bit rx_steady;
  bit pressure_req;

  lvp_in_if  in_ch ();
  lvp_out_if out_ch ();

  lfo_vibrato_pitch_engine dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lvp_pitch_checker u_pitch_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : receiver
    int hold;
    bit pressure_done;
    hold = 0;
    pressure_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        out_ch.ready <= (hold == 0);
      end else if (pressure_req && !pressure_done) begin
        pressure_done = 1'b1;
        hold = PRESSURE_HOLD;
        out_ch.ready <= 1'b0;
      end else if (rx_steady || $urandom_range(0, 99) < 65) begin
        out_ch.ready <= 1'b1;
      end else begin
        hold = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        out_ch.ready <= 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_setting(input int hi);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return hi;
      2: return 1;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                           input logic [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] value);
    int gap;
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.key         <= key;
    in_ch.entry_index <= idx;
    in_ch.entry_value <= value;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      send_item(MODE_TICK, $urandom, $urandom, $urandom);
    end else if (r < 84) begin
      send_item(MODE_PITCH_LOAD, $urandom,
                ($urandom_range(0, 9) == 0) ? $urandom_range(PITCH_TABLE_DEPTH, 1023)
                                            : $urandom_range(0, PITCH_TABLE_DEPTH - 1),
                $urandom);
    end else if (r < 96) begin
      send_item(MODE_WAVE_LOAD, $urandom,
                ($urandom_range(0, 9) == 0) ? $urandom_range(WAVE_DEPTH, 1023)
                                            : $urandom_range(0, WAVE_DEPTH - 1),
                $urandom);
    end else begin
      send_item(MODE_UNUSED, $urandom, $urandom, $urandom);
    end
  endtask

  // wait for every pitch item, then for the block to settle
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & 32'hFFFF_FF00) | (value & 32'hFF);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input int rate, input int depth, input int root,
                                input int tune, input int span, input int tri_on);
    drain_block();
    write_reg(REG_RATE, rate);
    write_reg(REG_DEPTH, depth);
    write_reg(REG_ROOT, root);
    write_reg(REG_TUNE, tune);
    write_reg(REG_RANGE, span);
    write_reg(REG_TRI, tri_on);
    settings_used++;
  endtask

  initial begin : stimulus
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_TICK;
    in_ch.key         <= '0;
    in_ch.entry_index <= '0;
    in_ch.entry_value <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    rx_steady         <= 1'b0;
    pressure_req      <= 1'b0;
    rst_n             <= 1'b0;
    tx_steady = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every table entry gets written before any tick can read it
    for (int i = 0; i < PITCH_TABLE_DEPTH; i++) send_item(MODE_PITCH_LOAD, $urandom, i, $urandom);
    for (int i = 0; i < WAVE_DEPTH; i++) send_item(MODE_WAVE_LOAD, $urandom, i, $urandom);

    // fastest rate, full depth: reload tick, advance, wrap
    apply_settings(127, 127, 0, 127, 127, 1);
    send_item(MODE_TICK, 7'd127, '0, '0);
    send_item(MODE_TICK, 7'd0, 10'h3FF, 16'hFFFF);
    send_item(MODE_PITCH_LOAD, 7'h7F, PITCH_TABLE_DEPTH - 1, 16'hFFFF);
    send_item(MODE_PITCH_LOAD, 7'h00, 10'd0, 16'h0000);
    send_item(MODE_PITCH_LOAD, 7'h00, 10'h3FF, 16'hFFFF);
    send_item(MODE_WAVE_LOAD, 7'h00, 10'd0, 16'hFFFF);
    send_item(MODE_WAVE_LOAD, 7'h00, WAVE_DEPTH - 1, 16'h0000);
    send_item(MODE_WAVE_LOAD, 7'h00, WAVE_DEPTH, 16'h5A5A);
    send_item(MODE_UNUSED, 7'h55, 10'h2AA, 16'hAAAA);
    send_item(MODE_TICK, 7'd127, 10'h155, 16'h5555);
    send_item(MODE_TICK, 7'd0, '0, '0);

    // slowest rate, loaded waveform, lowest tuning
    apply_settings(1, 1, 127, -128, 0, 0);
    send_item(MODE_TICK, 7'd0, '0, '0);
    send_item(MODE_TICK, 7'd127, '0, '0);
    send_item(MODE_TICK, 7'd64, '0, '0);

    // unarmed ticks
    drain_block();
    write_reg(REG_DEPTH, 0);
    send_item(MODE_TICK, 7'd10, '0, '0);
    send_item(MODE_TICK, 7'd100, '0, '0);
    drain_block();
    write_reg(REG_UNMAPPED, $urandom);

    // output held off while ticks keep coming
    apply_settings($urandom_range(1, 127), $urandom_range(1, 127), $urandom_range(0, 127),
                   $urandom_range(0, 255), $urandom_range(0, 127), $urandom_range(0, 1));
    tx_steady = 1'b1;
    pressure_req <= 1'b1;
    repeat (40) send_item(MODE_TICK, $urandom, $urandom, $urandom);
    tx_steady = 1'b0;

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      apply_settings(pick_setting(127), pick_setting(127), pick_setting(127),
                     pick_setting(255), pick_setting(127), $urandom_range(0, 1));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady <= ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) send_random_item();
    end

    tx_steady = 1'b0;
    drain_block();
    $display("%0d items sent under %0d register settings", items_sent, settings_used);
    $display("%0d pitch items compared, output hold-off of %0d cycles included",
             results_checked, PRESSURE_HOLD);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
